@@ rtl/rhsv_pkg.sv @@
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 16;

    // One quotient bit per cell; both quotients fit in sixteen bits.
    localparam int QUO_W  = 16;
    // Partial remainders stay below divisor * 2^16, divisor < 2^8.
    localparam int REM_W  = 24;
    localparam int HUE_Q_W = 12;

    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_TURN       = 15'd23040;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0]  hue_rem;
        logic [REM_W-1:0]  sat_rem;
        logic [QUO_W-1:0]  hue_quo;
        logic [QUO_W-1:0]  sat_quo;
        logic [CHAN_W-1:0] delta;
        logic [CHAN_W-1:0] cmax;
        logic [1:0]        sector;
        logic              neg;
    } cell_data_t;

endpackage

@@ rtl/rgb_to_hsv_pixel_converter.sv @@
`timescale 1ns / 1ps

// RGB to HSV pixel converter.
//
// The input channel (s_valid, s_ready, s_red_in, s_green_in, s_blue_in) takes
// one 8-bit RGB pixel per transaction. The output channel (m_valid, m_ready,
// m_hue, m_saturation, m_brightness) gives one HSV result per transaction,
// in input order. Hue is in 1/64 degree (0 to 23039, 0 for grey pixels),
// saturation is floor(65535*delta/max) and brightness is the largest byte.
//
// The path from input to output holds eighteen register stages, the first
// loaded at the input edge. They are one stage for the maximum, minimum and
// scaled dividends, sixteen cells that each resolve one quotient bit of both
// divisions, and one output register that assembles the hue. Throughput is
// one pixel per clock while m_ready stays high, set by the cells, each of
// which does one compare and subtract per division.
//
// Every stage carries its own valid bit and accepts new data when empty or
// when its successor takes its contents, so bubbles close up while the
// receiver stalls and the block keeps accepting until all stages are full.
// A synchronous reset (aresetn low) empties the pipeline; results in flight
// are dropped. There is no other state.

module rgb_to_hsv_pixel_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rhsv_pkg::CHAN_W-1:0]   s_red_in,
    input  logic [rhsv_pkg::CHAN_W-1:0]   s_green_in,
    input  logic [rhsv_pkg::CHAN_W-1:0]   s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhsv_pkg::HUE_W-1:0]    m_hue,
    output logic [rhsv_pkg::SAT_W-1:0]    m_saturation,
    output logic [rhsv_pkg::CHAN_W-1:0]   m_brightness
);
    import rhsv_pkg::*;

    // Link k feeds cell k; link QUO_W feeds the output stage. Cell k resolves
    // quotient bit QUO_W-1-k, most significant first.
    logic       link_valid [QUO_W+1];
    logic       link_ready [QUO_W+1];
    cell_data_t link_data  [QUO_W+1];

    rhsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_in  (s_valid),
        .ready_out (s_ready),
        .red_in    (s_red_in),
        .green_in  (s_green_in),
        .blue_in   (s_blue_in),
        .valid_out (link_valid[0]),
        .ready_in  (link_ready[0]),
        .data_out  (link_data[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rhsv_div_cell #(
            .BIT_POS (QUO_W - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .valid_in  (link_valid[k]),
            .ready_out (link_ready[k]),
            .data_in   (link_data[k]),
            .valid_out (link_valid[k+1]),
            .ready_in  (link_ready[k+1]),
            .data_out  (link_data[k+1])
        );
    end

    rhsv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .valid_in     (link_valid[QUO_W]),
        .ready_out    (link_ready[QUO_W]),
        .data_in      (link_data[QUO_W]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

endmodule

@@ rtl/rhsv_front.sv @@
`timescale 1ns / 1ps

module rhsv_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          valid_in,
    output logic                          ready_out,
    input  logic [rhsv_pkg::CHAN_W-1:0]   red_in,
    input  logic [rhsv_pkg::CHAN_W-1:0]   green_in,
    input  logic [rhsv_pkg::CHAN_W-1:0]   blue_in,
    output logic                          valid_out,
    input  logic                          ready_in,
    output rhsv_pkg::cell_data_t          data_out
);
    import rhsv_pkg::*;

    logic                 valid_reg, valid_next;
    cell_data_t           data_reg, data_next;
    logic [CHAN_W-1:0]    cmin;
    logic [CHAN_W:0]      diff;
    logic [CHAN_W-1:0]    mag;

    assign ready_out = !valid_reg || ready_in;

    always_comb begin
        data_next = '0;
        // Red wins ties, then green.
        if (red_in >= green_in && red_in >= blue_in) begin
            data_next.cmax   = red_in;
            data_next.sector = SECTOR_RED;
            diff = {1'b0, green_in} - {1'b0, blue_in};
        end else if (green_in >= blue_in) begin
            data_next.cmax   = green_in;
            data_next.sector = SECTOR_GREEN;
            diff = {1'b0, blue_in} - {1'b0, red_in};
        end else begin
            data_next.cmax   = blue_in;
            data_next.sector = SECTOR_BLUE;
            diff = {1'b0, red_in} - {1'b0, green_in};
        end
        cmin = (red_in <= green_in) ? red_in : green_in;
        if (blue_in < cmin) begin
            cmin = blue_in;
        end
        data_next.delta = data_next.cmax - cmin;
        data_next.neg   = diff[CHAN_W];
        mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        // 3840 * mag and 65535 * delta as shifts and one subtraction each.
        data_next.hue_rem = (REM_W'(mag) << 12) - (REM_W'(mag) << 8);
        data_next.sat_rem = (REM_W'(data_next.delta) << 16) - REM_W'(data_next.delta);
    end

    assign valid_next = ready_out ? valid_in : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ rtl/rhsv_div_cell.sv @@
`timescale 1ns / 1ps

module rhsv_div_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  valid_in,
    output logic                  ready_out,
    input  rhsv_pkg::cell_data_t  data_in,
    output logic                  valid_out,
    input  logic                  ready_in,
    output rhsv_pkg::cell_data_t  data_out
);
    import rhsv_pkg::*;

    logic             valid_reg, valid_next;
    cell_data_t       data_reg, data_next;
    logic [REM_W-1:0] hue_trial;
    logic [REM_W-1:0] sat_trial;

    assign ready_out = !valid_reg || ready_in;

    // One restoring step for each of the two divisions.
    always_comb begin
        data_next = data_in;
        hue_trial = REM_W'(data_in.delta) << BIT_POS;
        sat_trial = REM_W'(data_in.cmax) << BIT_POS;
        if (data_in.hue_rem >= hue_trial) begin
            data_next.hue_rem          = data_in.hue_rem - hue_trial;
            data_next.hue_quo[BIT_POS] = 1'b1;
        end
        if (data_in.sat_rem >= sat_trial) begin
            data_next.sat_rem          = data_in.sat_rem - sat_trial;
            data_next.sat_quo[BIT_POS] = 1'b1;
        end
    end

    assign valid_next = ready_out ? valid_in : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ rtl/rhsv_back.sv @@
`timescale 1ns / 1ps

module rhsv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          valid_in,
    output logic                          ready_out,
    input  rhsv_pkg::cell_data_t          data_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rhsv_pkg::HUE_W-1:0]    m_hue,
    output logic [rhsv_pkg::SAT_W-1:0]    m_saturation,
    output logic [rhsv_pkg::CHAN_W-1:0]   m_brightness
);
    import rhsv_pkg::*;

    logic               valid_reg, valid_next;
    logic [HUE_W-1:0]   hue_reg, hue_next;
    logic [SAT_W-1:0]   sat_reg, sat_next;
    logic [CHAN_W-1:0]  bright_reg;
    logic [HUE_Q_W:0]   down;
    logic [HUE_W-1:0]   quo;
    logic [HUE_W-1:0]   base;

    assign ready_out = !valid_reg || m_ready;

    always_comb begin
        quo  = HUE_W'(data_in.hue_quo[HUE_Q_W-1:0]);
        // Flooring a negative quotient: one more when the remainder is non-zero.
        down = {1'b0, data_in.hue_quo[HUE_Q_W-1:0]}
             + (HUE_Q_W+1)'(data_in.hue_rem != '0);
        unique case (data_in.sector)
            SECTOR_RED:   base = data_in.neg ? HUE_TURN : '0;
            SECTOR_GREEN: base = HUE_GREEN_BASE;
            SECTOR_BLUE:  base = HUE_BLUE_BASE;
            default:      base = '0;
        endcase
        if (data_in.delta == '0) begin
            hue_next = '0;
        end else if (data_in.neg) begin
            hue_next = base - HUE_W'(down);
        end else begin
            hue_next = base + quo;
        end
        sat_next = (data_in.cmax == '0) ? '0 : data_in.sat_quo;
    end

    assign valid_next = ready_out ? valid_in : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= data_in.cmax;
        end
    end

    assign m_valid      = valid_reg;
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;

endmodule

@@ rtl/rhsv_checker.sv @@
`timescale 1ns / 1ps

module rhsv_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [rhsv_pkg::HUE_W-1:0]    m_hue,
    input  logic [rhsv_pkg::SAT_W-1:0]    m_saturation,
    input  logic [rhsv_pkg::CHAN_W-1:0]   m_brightness
);
    import rhsv_pkg::*;

    // A stalled result holds until taken.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue) && $stable(m_saturation)
                                && $stable(m_brightness))
        else $error("output transaction changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue < HUE_TURN)
        else $error("hue beyond a full turn");

    // A black pixel has no saturation.
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brightness == '0 |-> m_saturation == '0)
        else $error("saturation on a black pixel");

    // Zero saturation means a grey pixel, whose hue is zero.
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation == '0 |-> m_hue == '0)
        else $error("hue on a grey pixel");

endmodule

bind rgb_to_hsv_pixel_converter rhsv_checker u_rhsv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hue        (m_hue),
    .m_saturation (m_saturation),
    .m_brightness (m_brightness)
);

@@ tb/tb_rgb_to_hsv_pixel_converter.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the RGB to HSV pixel converter.
//
// Pixels wait in a queue that the stimulus process fills. A driver clocked on
// the falling edge presents them on the input channel, and a monitor clocked
// on the rising edge sees every transaction on both channels. For each input
// transaction the monitor predicts the HSV result and appends it to a queue.
// Each output transaction is then compared, field by field, with the oldest
// prediction in that queue.
module tb_rgb_to_hsv_pixel_converter;

    import rhsv_pkg::*;

    // One sixth of a turn, in hue units of 1/64 degree.
    localparam int HUE_SIXTH     = 3840;
    // Full scale of the saturation field.
    localparam int SAT_FULL      = 65535;
    // The pipeline is 18 deep, so this is ample time for stray results to show.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without a transaction on either channel before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 476;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t            pixel;
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [CHAN_W-1:0] val;
    } hsv_expect_t;

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [CHAN_W-1:0] s_red_in     = '0;
    logic [CHAN_W-1:0] s_green_in   = '0;
    logic [CHAN_W-1:0] s_blue_in    = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [HUE_W-1:0]  m_hue;
    logic [SAT_W-1:0]  m_saturation;
    logic [CHAN_W-1:0] m_brightness;

    pixel_t      pixel_queue[$];
    hsv_expect_t hsv_expected[$];
    pixel_t      next_pixel;
    hsv_expect_t oldest_hsv;
    logic        pixel_taken    = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          mismatch_count = 0;

    rgb_to_hsv_pixel_converter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor(HUE_SIXTH * num / den) for den > 0. Negative quotients must round
    // towards minus infinity, which plain integer division does not do.
    function automatic int sixth_floor(input int num, input int den);
        int scaled;
        scaled = HUE_SIXTH * num;
        if (scaled >= 0) begin
            return scaled / den;
        end
        return -((-scaled + den - 1) / den);
    endfunction

    // Expected HSV value of one pixel. Ties for the maximum go to red first,
    // then green; a grey pixel has hue 0 and a black pixel saturation 0.
    function automatic hsv_expect_t predict_hsv(input pixel_t pix);
        hsv_expect_t res;
        int r, g, b, top, bottom, spread, angle, sat;
        r      = pix.red;
        g      = pix.green;
        b      = pix.blue;
        top    = (r > g) ? r : g;
        if (b > top) begin
            top = b;
        end
        bottom = (r < g) ? r : g;
        if (b < bottom) begin
            bottom = b;
        end
        spread = top - bottom;
        if (spread == 0) begin
            angle = 0;
        end else if (top == r) begin
            angle = sixth_floor(g - b, spread);
            if (angle < 0) begin
                angle += int'(HUE_TURN);
            end
        end else if (top == g) begin
            angle = int'(HUE_GREEN_BASE) + sixth_floor(b - r, spread);
        end else begin
            angle = int'(HUE_BLUE_BASE) + sixth_floor(r - g, spread);
        end
        sat       = (top == 0) ? 0 : (SAT_FULL * spread) / top;
        res.pixel = pix;
        res.hue   = angle[HUE_W-1:0];
        res.sat   = sat[SAT_W-1:0];
        res.val   = top[CHAN_W-1:0];
        return res;
    endfunction

    // Random pixel, weighted towards ties, greys and near-greys, which are
    // where the sector choice and the hue division are most delicate.
    function automatic pixel_t random_pixel();
        pixel_t     pix;
        logic [7:0] base;
        logic [1:0] pick;
        pix.red   = CHAN_W'($urandom_range(255));
        pix.green = CHAN_W'($urandom_range(255));
        pix.blue  = CHAN_W'($urandom_range(255));
        base      = CHAN_W'($urandom_range(255));
        case ($urandom_range(9))
            6: begin
                pick = 2'($urandom_range(2));
                if (pick == 2'd0) begin
                    pix.green = pix.red;
                end else if (pick == 2'd1) begin
                    pix.blue = pix.green;
                end else begin
                    pix.blue = pix.red;
                end
            end
            7: begin
                pix = '{base, base, base};
            end
            8: begin
                pix.red   = base;
                pix.green = base ^ CHAN_W'($urandom_range(3));
                pix.blue  = base ^ CHAN_W'($urandom_range(3));
            end
            9: begin
                pick      = 2'($urandom_range(3));
                pix.red   = {{7{pick[1]}}, pick[0]};
                pick      = 2'($urandom_range(3));
                pix.green = {{7{pick[1]}}, pick[0]};
                pick      = 2'($urandom_range(3));
                pix.blue  = {{7{pick[1]}}, pick[0]};
            end
            default: begin
            end
        endcase
        return pix;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Driver. All inputs change on the falling edge so that the block sees
    // them settled at the next rising edge. A pixel stays on the bus, with
    // valid high, until the monitor has seen its transaction complete.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || pixel_taken) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pixel = pixel_queue.pop_front();
                    s_red_in   <= next_pixel.red;
                    s_green_in <= next_pixel.green;
                    s_blue_in  <= next_pixel.blue;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. On each rising edge it records an input transaction as a new
    // prediction, then checks any output transaction against the oldest one.
    always @(posedge aclk) begin
        pixel_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            hsv_expected.push_back(predict_hsv('{s_red_in, s_green_in, s_blue_in}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (hsv_expected.size() == 0) begin
                note_failure($sformatf("result with nothing expected: hue %0d sat %0d val %0d",
                                       m_hue, m_saturation, m_brightness));
            end else begin
                oldest_hsv = hsv_expected.pop_front();
                if (m_hue !== oldest_hsv.hue || m_saturation !== oldest_hsv.sat ||
                    m_brightness !== oldest_hsv.val) begin
                    note_failure($sformatf(
                        "rgb %0d,%0d,%0d: expected hue %0d sat %0d val %0d, got %0d %0d %0d",
                        oldest_hsv.pixel.red, oldest_hsv.pixel.green, oldest_hsv.pixel.blue,
                        oldest_hsv.hue, oldest_hsv.sat, oldest_hsv.val,
                        m_hue, m_saturation, m_brightness));
                end
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a long stretch with no transaction on either channel means
    // the block has hung, so the run is ended here.
    initial begin
        wait (aresetn);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge aclk);
        end
        $display("tb_rgb_to_hsv_pixel_converter NOT OK");
        $finish;
    end

    // Stimulus. The corner pixels come first: black, white, greys, the pure
    // primaries, every tie for the maximum, red-maximum pixels whose hue
    // wraps below zero, the smallest non-zero maximum and one-step deltas.
    // Three random phases follow with different idling on each side. Between
    // phases the sender holds off until every predicted result has arrived.
    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        pixel_queue = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
            24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
            24'h01FF00, 24'h00FF01, 24'h0001FF, 24'h0100FF, 24'h010000, 24'h000001,
            24'hFFFEFE, 24'hFEFFFE, 24'hFEFEFF, 24'hAA5500, 24'h7F80FF
        };

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 58;
                end
                1: begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 32;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PIXELS; n++) begin
                pixel_queue.push_back(random_pixel());
            end
            // Wait until the queue is empty and every result has come back.
            do begin
                @(negedge aclk);
            end while (pixel_queue.size() != 0 || s_valid || hsv_expected.size() != 0);
        end

        // Allow the pipeline time to show any result that nobody asked for.
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (hsv_expected.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", hsv_expected.size()));
        end

        if (mismatch_count == 0) begin
            $display("tb_rgb_to_hsv_pixel_converter OK");
        end else begin
            $display("tb_rgb_to_hsv_pixel_converter NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rhsv_pkg.sv
rtl/rhsv_front.sv
rtl/rhsv_div_cell.sv
rtl/rhsv_back.sv
rtl/rgb_to_hsv_pixel_converter.sv
rtl/rhsv_checker.sv
tb/tb_rgb_to_hsv_pixel_converter.sv
